// File: hdl/rar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int NW = 2 * OPERAND_WIDTH + 1;
  localparam int DW = 2 * OPERAND_WIDTH;
  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int KW = $clog2(MW + 1);
  localparam int CW = $clog2(MW);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_NORM = 2'd0,
    K_ZERO = 2'd1,
    K_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic signed [NW-1:0]  n;
    logic signed [DW-1:0]  d;
  } entry_t;
endpackage
`default_nettype wire

// File: hdl/rar_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rar_front (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      push,
  output logic                                           full,
  input  wire logic [1:0]                                operation,
  input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0]  a_num,
  input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0]  a_den,
  input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0]  b_num,
  input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0]  b_den,
  output logic                                           f_valid,
  output rar_pkg::entry_t                                f_entry,
  input  wire logic                                      q_full
);
  logic                                         accept;
  rar_pkg::op_t                                 op;
  logic signed [rar_pkg::OPERAND_WIDTH-1:0]     bsel;
  logic signed [rar_pkg::DW-1:0]                m1, m2, m3;
  logic signed [rar_pkg::NW-1:0]                e1, e2, n;
  logic signed [rar_pkg::DW-1:0]                d;

  assign full   = f_valid && q_full;
  assign accept = push && !full;
  assign bsel   = (rar_pkg::op_t'(operation) == rar_pkg::OP_MUL) ? b_num : b_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept || (f_valid && q_full);
    end
    if (accept) begin
      op <= rar_pkg::op_t'(operation);
      m1 <= a_num * bsel;
      m2 <= b_num * a_den;
      m3 <= a_den * b_den;
    end
  end

  assign e1 = {m1[rar_pkg::DW-1], m1};
  assign e2 = {m2[rar_pkg::DW-1], m2};

  always_comb begin
    unique case (op)
      rar_pkg::OP_ADD: begin n = e1 + e2; d = m3; end
      rar_pkg::OP_SUB: begin n = e1 - e2; d = m3; end
      rar_pkg::OP_MUL: begin n = e1;      d = m3; end
      default:         begin n = e1;      d = m2; end
    endcase
  end

  always_comb begin
    f_entry.n = n;
    f_entry.d = d;
    priority if (d == '0) f_entry.kind = rar_pkg::K_ERR;
    else if (n == '0)     f_entry.kind = rar_pkg::K_ZERO;
    else                  f_entry.kind = rar_pkg::K_NORM;
  end
endmodule
`default_nettype wire

// File: hdl/rar_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rar_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire rar_pkg::entry_t  wr_entry,
  output logic                  q_full,
  output logic                  q_valid,
  output rar_pkg::entry_t       rd_entry,
  input  wire logic             rd
);
  rar_pkg::entry_t  mem [2];
  logic             wp, rp;
  logic [1:0]       cnt;
  logic             do_wr, do_rd;

  assign q_full   = (cnt == 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign do_wr    = wr && !q_full;
  assign do_rd    = rd && q_valid;
  assign rd_entry = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) mem[wp] <= wr_entry;
  end
endmodule
`default_nettype wire

// File: hdl/rar_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rar_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                q_valid,
  input  wire rar_pkg::entry_t                     q_entry,
  output logic                                     q_take,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic signed [rar_pkg::NW-1:0]            num,
  output logic signed [rar_pkg::DW-1:0]            den,
  output logic                                     error
);
  localparam int MW = rar_pkg::MW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIX  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                         state;
  logic                           out_valid;
  logic [MW-1:0]                  x, y, g, qn, qd;
  logic [MW:0]                    rn, rd;
  logic [rar_pkg::KW-1:0]         k;
  logic [rar_pkg::CW-1:0]         cnt;
  logic                           n_neg, d_neg;
  logic signed [rar_pkg::NW-1:0]  res_num;
  logic signed [rar_pkg::DW-1:0]  res_den;
  logic                           res_err;
  logic [rar_pkg::NW-1:0]         n_negv;
  logic [rar_pkg::DW-1:0]         d_negv;
  logic [MW-1:0]                  n_mag, d_mag;
  logic [MW:0]                    tn, td;
  logic                           ge_n, ge_d;

  assign empty  = !out_valid;
  assign q_take = (state == S_IDLE) && q_valid;

  assign n_negv = -q_entry.n;
  assign d_negv = -q_entry.d;
  assign n_mag  = q_entry.n[rar_pkg::NW-1] ? n_negv[MW-1:0] : q_entry.n[MW-1:0];
  assign d_mag  = q_entry.d[rar_pkg::DW-1] ? d_negv[MW-1:0] : q_entry.d[MW-1:0];

  // restoring division step, one quotient bit per cycle for each word
  assign tn   = {rn[MW-1:0], qn[MW-1]};
  assign td   = {rd[MW-1:0], qd[MW-1]};
  assign ge_n = tn >= {1'b0, g};
  assign ge_d = td >= {1'b0, g};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded below
      if (pop && out_valid && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            x     <= n_mag;
            y     <= d_mag;
            qn    <= n_mag;
            qd    <= d_mag;
            k     <= '0;
            n_neg <= q_entry.n[rar_pkg::NW-1];
            d_neg <= q_entry.d[rar_pkg::DW-1];
            unique case (q_entry.kind)
              rar_pkg::K_ERR: begin
                res_num <= '0; res_den <= '0; res_err <= 1'b1; state <= S_DONE;
              end
              rar_pkg::K_ZERO: begin
                res_num <= '0; res_den <= rar_pkg::DW'(1); res_err <= 1'b0;
                state <= S_DONE;
              end
              default: state <= S_GCD;
            endcase
          end
        end
        S_GCD: begin
          // binary gcd, one step per cycle
          priority if (x == y) begin
            g     <= x << k;
            rn    <= '0;
            rd    <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x > y) begin
            x <= (x - y) >> 1;
          end else begin
            y <= (y - x) >> 1;
          end
        end
        S_DIV: begin
          rn  <= ge_n ? tn - {1'b0, g} : tn;
          rd  <= ge_d ? td - {1'b0, g} : td;
          qn  <= {qn[MW-2:0], ge_n};
          qd  <= {qd[MW-2:0], ge_d};
          cnt <= cnt + 1'b1;
          if (cnt == rar_pkg::CW'(MW - 1)) state <= S_FIX;
        end
        S_FIX: begin
          res_num <= n_neg ? -{1'b0, qn} : {1'b0, qn};
          res_den <= d_neg ? -qd : qd;
          res_err <= 1'b0;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            num       <= res_num;
            den       <= res_den;
            error     <= res_err;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/rational_arith_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// rational_arith_reduce: a_num/a_den op b_num/b_den, reduced by the gcd
// input side is a queue: drive the word on operation and operands with push
// high; it is taken on an edge where full is low
// result side is a queue: num, den, error are valid while empty is low; pop
// takes the word
// the front stage forms the cross products and classifies the word (zero
// denominator -> error with 0/0, zero numerator -> 0/1), then a two-entry
// queue feeds the back end
// the back end runs a binary gcd (one step per cycle) and then divides both
// words by it in 32 restoring steps; zero and error words skip the gcd loop
// and the divider
// reset empties all stages; nothing is lost while pop is held low, the back
// end waits on a full result register and the queue then fills and asserts
// full
module rational_arith_reduce (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      push,
  output logic                                           full,
  input  wire logic [1:0]                                operation,
  input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0]  a_num,
  input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0]  a_den,
  input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0]  b_num,
  input  wire logic signed [rar_pkg::OPERAND_WIDTH-1:0]  b_den,
  output logic                                           empty,
  input  wire logic                                      pop,
  output logic signed [rar_pkg::NW-1:0]                  num,
  output logic signed [rar_pkg::DW-1:0]                  den,
  output logic                                           error
);
  logic             f_valid, q_full, q_valid, q_take;
  rar_pkg::entry_t  f_entry, q_entry;

  rar_front u_front (
    .clk, .rst, .push, .full, .operation, .a_num, .a_den, .b_num, .b_den,
    .f_valid, .f_entry, .q_full
  );

  rar_queue u_queue (
    .clk, .rst, .wr(f_valid), .wr_entry(f_entry), .q_full, .q_valid,
    .rd_entry(q_entry), .rd(q_take)
  );

  rar_back u_back (
    .clk, .rst, .q_valid, .q_entry, .q_take, .empty, .pop, .num, .den, .error
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (num == '0 && den == '0))
    else $error("error word with nonzero payload");
  a_den_nz: assert property (@(posedge clk) disable iff (rst)
    (!empty && !error) |-> (den != '0))
    else $error("valid word with zero denominator");
  a_zero_one: assert property (@(posedge clk) disable iff (rst)
    (!empty && !error && num == '0) |-> (den == rar_pkg::DW'(1)))
    else $error("zero numerator without unit denominator");
endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  localparam int W = rar_pkg::OPERAND_WIDTH;
  localparam int NW = rar_pkg::NW;
  localparam int DW = rar_pkg::DW;
  localparam longint MAX_CYCLES = 1500000;

  typedef struct {
    logic signed [NW-1:0] num;
    logic signed [DW-1:0] den;
    logic                 error;
  } fraction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] operation = '0;
  logic signed [W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic full, empty, error;
  logic signed [NW-1:0] num;
  logic signed [DW-1:0] den;

  fraction_t pending_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fails = 0;
  longint cycles = 0;

  rational_arith_reduce dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .empty(empty), .pop(pop), .num(num), .den(den), .error(error)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic fraction_t reduce_fraction(rar_pkg::op_t op, logic signed [W-1:0] an,
      logic signed [W-1:0] ad, logic signed [W-1:0] bn, logic signed [W-1:0] bd);
    longint n, d, g;
    longint unsigned x, y, t;
    fraction_t r;
    case (op)
      rar_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      rar_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      rar_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
      default: begin n = an * bd; d = ad * bn; end
    endcase
    r.error = 1'b0;
    if (d == 0) begin
      r.num = '0; r.den = '0; r.error = 1'b1;
    end else if (n == 0) begin
      r.num = '0; r.den = DW'(1);
    end else begin
      x = mag64(n); y = mag64(d);
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      g = longint'(x);
      r.num = NW'(n / g);
      r.den = DW'(d / g);
    end
    return r;
  endfunction

  // result side: random stall, compare with oldest expectation
  always @(negedge clk) begin
    if (!rst) pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    fraction_t e;
    if (!rst && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word num=%0d den=%0d error=%0b", $time, num, den, error);
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (num !== e.num || den !== e.den || error !== e.error) begin
          $display("%0t: mismatch expected %0d/%0d err %0b, actual %0d/%0d err %0b",
                   $time, e.num, e.den, e.error, num, den, error);
          fails++;
        end
      end
    end
  end

  // push stays high between back-to-back words; callers drop it via drain_results
  task automatic send_word(rar_pkg::op_t op, logic signed [W-1:0] an,
                           logic signed [W-1:0] ad, logic signed [W-1:0] bn,
                           logic signed [W-1:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    operation <= op; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_q.push_back(reduce_fraction(op, an, ad, bn, bd));
    @(negedge clk);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic signed [W-1:0] mn, mx;
    mn = {1'b1, {(W-1){1'b0}}};
    mx = {1'b0, {(W-1){1'b1}}};
    for (int o = 0; o < 4; o++) begin
      send_word(rar_pkg::op_t'(o), W'(1), W'(2), W'(1), W'(3));
      send_word(rar_pkg::op_t'(o), mn, mn, mn, mn);
      send_word(rar_pkg::op_t'(o), mx, mn, mx, mn);
    end
    send_word(rar_pkg::OP_ADD, W'(1), W'(0), W'(1), W'(5));      // zero denominator
    send_word(rar_pkg::OP_DIV, W'(3), W'(4), W'(0), W'(7));      // divide by zero fraction
    send_word(rar_pkg::OP_MUL, W'(0), W'(4), W'(5), W'(7));      // zero numerator
    send_word(rar_pkg::OP_SUB, W'(2), W'(3), W'(2), W'(3));      // difference cancels
    send_word(rar_pkg::OP_ADD, W'(-1), W'(2), W'(1), W'(-3));    // negative denominator kept
    send_word(rar_pkg::OP_DIV, mx, W'(-1), mn, mx);
    send_word(rar_pkg::OP_MUL, mn, mx, mx, mn);
    send_word(rar_pkg::OP_ADD, mn, W'(1), mn, W'(1));
    send_word(rar_pkg::OP_SUB, mx, W'(1), mn, W'(1));
    send_word(rar_pkg::OP_DIV, W'(0), W'(0), W'(0), W'(0));
    drain_results();
  endtask

  function automatic logic signed [W-1:0] rand_operand();
    case ($urandom_range(3))
      0: return W'($urandom_range(16)) - W'(8);
      1: return W'($urandom);
      2: return $urandom_range(1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      default: return W'($urandom_range(255)) - W'(128);
    endcase
  endfunction

  task automatic test_random(int count);
    logic signed [W-1:0] ad, bd;
    for (int i = 0; i < count; i++) begin
      ad = rand_operand();
      bd = rand_operand();
      if ($urandom_range(99) < 3) ad = '0;
      send_word(rar_pkg::op_t'($urandom_range(3)), rand_operand(), ad, rand_operand(), bd);
      // hold off until the pipe is empty once, halfway through the run
      if (i == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 22; recv_idle_pct = 81;
    test_random(580);
    send_idle_pct = 81; recv_idle_pct = 22;
    test_random(580);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(580);
    repeat (200) @(posedge clk);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
